@@ design/gle_pkg.sv @@
// gle_pkg: shared constants, types and the slot hash for the gif lzw encoder
// no dependencies
`timescale 1ns / 1ps
package gle_pkg;

  localparam int HASH_SLOTS      = 8192;
  localparam int HASH_W          = $clog2(HASH_SLOTS);
  localparam int SUB_BLOCK_BYTES = 255;
  localparam int DICT_LIMIT      = 4096;
  localparam int WIDTH_LIMIT     = 12;
  localparam int KEY_W           = 20;
  localparam int CODE_W          = 12;
  localparam int GEN_W           = 16;

  // one dictionary slot as stored in the hash memory
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
    logic [GEN_W-1:0]  gen;
  } slot_t;

  // outcome of one probe, valid the cycle after the read
  typedef struct packed {
    logic              stale;
    logic              hit;
    logic [CODE_W-1:0] code;
  } probe_t;

  // xor-shift fold of the key onto the slot index
  function automatic logic [HASH_W-1:0] hash_of(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] h1;
    logic [KEY_W-1:0] h2;
    h1 = key ^ (key >> 16);
    h2 = h1 ^ (h1 >> 8);
    return h2[HASH_W-1:0];
  endfunction

endpackage

@@ design/gle_table.sv @@
// gle_table: dictionary hash memory with registered read and probe compare
// depends on gle_pkg
`timescale 1ns / 1ps
module gle_table import gle_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [HASH_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [HASH_W-1:0] wr_addr,
  input  slot_t             wr_data,
  input  logic [KEY_W-1:0]  key,
  input  logic [GEN_W-1:0]  generation,
  output probe_t            probe
);

  slot_t mem [HASH_SLOTS];
  slot_t rd_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // a slot of another generation is empty
  always_comb begin
    probe.stale = (rd_q.gen != generation);
    probe.hit   = !probe.stale && (rd_q.key == key);
    probe.code  = rd_q.code;
  end

endmodule

@@ design/gif_lzw_encoder.sv @@
// gif_lzw_encoder: gif variable-width lzw code-stream encoder, top level
// depends on gle_pkg and gle_table
`timescale 1ns / 1ps
// usage
//   input channel (in_valid/in_ready) takes one word per pixel: pixel and
//   last_pixel. output channel (out_valid/out_ready) gives one word per packed
//   code-stream byte with block_end, stream_end and last_of_run flags.
//   the code size register sits at apb address 0 and is latched when a
//   stream starts.
// flow
//   one pixel at a time. a pixel that hits on the first probe goes through
//   accept, dispatch, read, compare, tail and final before the next accept.
//   a first-probe miss also puts the prefix code and drains its bytes. every
//   further probe adds one memory read and one compare, every further code
//   put adds a put step and the drain of its bytes in the byte packer.
// reset
//   a clearing pass writes all 8192 slots to zero; in_ready stays
//   low meanwhile. the same pass runs when the generation counter wraps.
// stalls
//   the newest byte waits in a hold register until the next byte or the end
//   of the pixel tells its last_of_run flag; the packer stops while the output
//   register is full and not taken. in_ready returns once the pixel's last
//   byte has moved into the output register.
module gif_lzw_encoder import gle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  input  logic        last_pixel,
  // byte channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        block_end,
  output logic        stream_end,
  output logic        last_of_run
);

  typedef enum logic [12:0] {
    ST_SWEEP    = 13'b0000000000001,
    ST_IDLE     = 13'b0000000000010,
    ST_PUT      = 13'b0000000000100,
    ST_DRAIN    = 13'b0000000001000,
    ST_BODY     = 13'b0000000010000,
    ST_PROBE_RD = 13'b0000000100000,
    ST_PROBE_CK = 13'b0000001000000,
    ST_MISS     = 13'b0000010000000,
    ST_FULL     = 13'b0000100000000,
    ST_TAIL     = 13'b0001000000000,
    ST_LAST_END = 13'b0010000000000,
    ST_FLUSH    = 13'b0100000000000,
    ST_FINAL    = 13'b1000000000000
  } state_t;

  // control registers
  state_t              state, state_next;
  state_t              put_ret, put_ret_next;
  state_t              sweep_ret, sweep_ret_next;
  logic                sweep_wrap, sweep_wrap_next;
  logic [HASH_W-1:0]   sweep_addr, sweep_addr_next;
  logic [3:0]          size_cfg;
  logic [3:0]          lsize, lsize_next;
  logic [GEN_W-1:0]    generation, generation_next;
  logic [CODE_W-1:0]   prefix, prefix_next;
  logic                prefix_valid, prefix_valid_next;
  logic [12:0]         nfc, nfc_next;
  logic [3:0]          cw, cw_next;
  logic [23:0]         acc, acc_next;
  logic [4:0]          bc, bc_next;
  logic [7:0]          bbc, bbc_next;
  logic                started, started_next;
  logic                hold_valid, hold_valid_next;
  logic                out_valid_next;
  // payload registers
  logic [7:0]          pixel_q, pixel_q_next;
  logic                last_q, last_q_next;
  logic [CODE_W-1:0]   pcode, pcode_next;
  logic [HASH_W-1:0]   idx, idx_next;
  logic [HASH_W-1:0]   tries, tries_next;
  logic                ins_ok, ins_ok_next;
  logic [7:0]          hold_byte, hold_byte_next;
  logic                hold_be, hold_be_next;
  logic [7:0]          out_byte_next;
  logic                block_end_next, stream_end_next, last_of_run_next;

  // table port
  logic                rd_en, wr_en;
  logic [HASH_W-1:0]   wr_addr;
  slot_t               wr_data;
  probe_t              probe;
  logic [KEY_W-1:0]    key;

  // helpers
  logic                can_push;
  logic [3:0]          eff_size;
  logic [CODE_W-1:0]   clr_code;
  logic [CODE_W-1:0]   masked;
  logic                emit_go;
  logic [7:0]          bbc_inc;
  logic                be_new;
  logic [GEN_W-1:0]    gen_inc;

  assign key      = {prefix, pixel_q};
  assign can_push = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {28'd0, size_cfg};

  // apb register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= 4'd8;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      size_cfg <= pwdata[3:0];
    end
  end

  gle_table u_table (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (idx),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .key        (key),
    .generation (generation),
    .probe      (probe)
  );

  always_comb begin
    priority if (size_cfg < 4'd2) begin
      eff_size = 4'd2;
    end else if (size_cfg > 4'd8) begin
      eff_size = 4'd8;
    end else begin
      eff_size = size_cfg;
    end
  end

  assign clr_code   = CODE_W'(12'd1 << lsize);
  assign masked     = pcode & ~(12'hFFF << cw);
  // a new byte can enter the hold register once the old one can leave
  assign emit_go    = !hold_valid || can_push;
  assign bbc_inc    = bbc + 8'd1;
  assign be_new     = (bbc_inc >= 8'(SUB_BLOCK_BYTES));
  assign gen_inc    = generation + 16'd1;

  always_comb begin
    state_next        = state;
    put_ret_next      = put_ret;
    sweep_ret_next    = sweep_ret;
    sweep_wrap_next   = sweep_wrap;
    sweep_addr_next   = sweep_addr;
    lsize_next        = lsize;
    generation_next   = generation;
    prefix_next       = prefix;
    prefix_valid_next = prefix_valid;
    nfc_next          = nfc;
    cw_next           = cw;
    acc_next          = acc;
    bc_next           = bc;
    bbc_next          = bbc;
    started_next      = started;
    hold_valid_next   = hold_valid;
    pixel_q_next      = pixel_q;
    last_q_next       = last_q;
    pcode_next        = pcode;
    idx_next          = idx;
    tries_next        = tries;
    ins_ok_next       = ins_ok;
    hold_byte_next    = hold_byte;
    hold_be_next      = hold_be;
    out_valid_next    = out_valid && !out_ready;
    out_byte_next     = out_byte;
    block_end_next    = block_end;
    stream_end_next   = stream_end;
    last_of_run_next  = last_of_run;
    rd_en             = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = idx;
    wr_data           = '0;

    unique case (state)
      ST_SWEEP: begin
        wr_en           = 1'b1;
        wr_addr         = sweep_addr;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == '1) begin
          state_next = sweep_ret;
          if (sweep_wrap) begin
            generation_next = 16'd1;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          pixel_q_next = pixel;
          last_q_next  = last_pixel;
          if (!started) begin
            // stream start: open a dictionary and send the clear code
            lsize_next        = eff_size;
            nfc_next          = (13'd1 << eff_size) + 13'd2;
            cw_next           = eff_size + 4'd1;
            generation_next   = gen_inc;
            started_next      = 1'b1;
            prefix_valid_next = 1'b0;
            pcode_next        = CODE_W'(12'd1 << eff_size);
            put_ret_next      = ST_BODY;
            if (gen_inc == '0) begin
              state_next      = ST_SWEEP;
              sweep_ret_next  = ST_PUT;
              sweep_wrap_next = 1'b1;
            end else begin
              state_next = ST_PUT;
            end
          end else begin
            state_next = ST_BODY;
          end
        end
      end
      ST_PUT: begin
        acc_next   = acc | (24'(masked) << bc);
        bc_next    = bc + 5'(cw);
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (bc >= 5'd8) begin
          if (emit_go) begin
            if (hold_valid) begin
              out_valid_next   = 1'b1;
              out_byte_next    = hold_byte;
              block_end_next   = hold_be;
              stream_end_next  = 1'b0;
              last_of_run_next = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = acc[7:0];
            hold_be_next    = be_new;
            bbc_next        = be_new ? 8'd0 : bbc_inc;
            acc_next        = acc >> 8;
            bc_next         = bc - 5'd8;
          end
        end else begin
          state_next = put_ret;
        end
      end
      ST_BODY: begin
        if (!prefix_valid) begin
          prefix_next       = CODE_W'(pixel_q);
          prefix_valid_next = 1'b1;
          state_next        = ST_TAIL;
        end else begin
          idx_next   = hash_of(key);
          tries_next = '0;
          state_next = ST_PROBE_RD;
        end
      end
      ST_PROBE_RD: begin
        rd_en      = 1'b1;
        state_next = ST_PROBE_CK;
      end
      ST_PROBE_CK: begin
        priority if (probe.stale) begin
          ins_ok_next  = 1'b1;
          pcode_next   = prefix;
          put_ret_next = ST_MISS;
          state_next   = ST_PUT;
        end else if (probe.hit) begin
          prefix_next = probe.code;
          state_next  = ST_TAIL;
        end else if (tries == '1) begin
          // every slot tried: miss and drop the insert
          ins_ok_next  = 1'b0;
          pcode_next   = prefix;
          put_ret_next = ST_MISS;
          state_next   = ST_PUT;
        end else begin
          tries_next = tries + 1'b1;
          idx_next   = idx + 1'b1;
          state_next = ST_PROBE_RD;
        end
      end
      ST_MISS: begin
        if (nfc < 13'(DICT_LIMIT)) begin
          if (ins_ok) begin
            wr_en        = 1'b1;
            wr_addr      = idx;
            wr_data.key  = key;
            wr_data.code = nfc[CODE_W-1:0];
            wr_data.gen  = generation;
          end
          if (nfc >= (13'd1 << cw) && cw < 4'(WIDTH_LIMIT)) begin
            cw_next = cw + 4'd1;
          end
          nfc_next    = nfc + 13'd1;
          prefix_next = CODE_W'(pixel_q);
          state_next  = ST_TAIL;
        end else begin
          // dictionary full: clear code at the current width
          pcode_next   = clr_code;
          put_ret_next = ST_FULL;
          state_next   = ST_PUT;
        end
      end
      ST_FULL: begin
        nfc_next        = (13'd1 << lsize) + 13'd2;
        cw_next         = lsize + 4'd1;
        generation_next = gen_inc;
        prefix_next     = CODE_W'(pixel_q);
        if (gen_inc == '0) begin
          state_next      = ST_SWEEP;
          sweep_ret_next  = ST_TAIL;
          sweep_wrap_next = 1'b1;
        end else begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (last_q) begin
          pcode_next   = prefix;
          put_ret_next = ST_LAST_END;
          state_next   = ST_PUT;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_LAST_END: begin
        pcode_next   = clr_code + 12'd1;
        put_ret_next = ST_FLUSH;
        state_next   = ST_PUT;
      end
      ST_FLUSH: begin
        if (bc == 5'd0 || emit_go) begin
          if (bc != 5'd0) begin
            if (hold_valid) begin
              out_valid_next   = 1'b1;
              out_byte_next    = hold_byte;
              block_end_next   = hold_be;
              stream_end_next  = 1'b0;
              last_of_run_next = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = acc[7:0];
            hold_be_next    = be_new;
          end
          acc_next          = '0;
          bc_next           = '0;
          bbc_next          = '0;
          prefix_valid_next = 1'b0;
          started_next      = 1'b0;
          state_next        = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!hold_valid) begin
          state_next = ST_IDLE;
        end else if (can_push) begin
          out_valid_next   = 1'b1;
          out_byte_next    = hold_byte;
          block_end_next   = hold_be;
          stream_end_next  = last_q;
          last_of_run_next = 1'b1;
          hold_valid_next  = 1'b0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      put_ret      <= ST_IDLE;
      sweep_ret    <= ST_IDLE;
      sweep_wrap   <= 1'b0;
      sweep_addr   <= '0;
      lsize        <= 4'd8;
      generation   <= '0;
      prefix       <= '0;
      prefix_valid <= 1'b0;
      nfc          <= 13'd258;
      cw           <= 4'd9;
      acc          <= '0;
      bc           <= '0;
      bbc          <= '0;
      started      <= 1'b0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      put_ret      <= put_ret_next;
      sweep_ret    <= sweep_ret_next;
      sweep_wrap   <= sweep_wrap_next;
      sweep_addr   <= sweep_addr_next;
      lsize        <= lsize_next;
      generation   <= generation_next;
      prefix       <= prefix_next;
      prefix_valid <= prefix_valid_next;
      nfc          <= nfc_next;
      cw           <= cw_next;
      acc          <= acc_next;
      bc           <= bc_next;
      bbc          <= bbc_next;
      started      <= started_next;
      hold_valid   <= hold_valid_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pixel_q     <= pixel_q_next;
    last_q      <= last_q_next;
    pcode       <= pcode_next;
    idx         <= idx_next;
    tries       <= tries_next;
    ins_ok      <= ins_ok_next;
    hold_byte   <= hold_byte_next;
    hold_be     <= hold_be_next;
    out_byte    <= out_byte_next;
    block_end   <= block_end_next;
    stream_end  <= stream_end_next;
    last_of_run <= last_of_run_next;
  end

endmodule

@@ design/gle_checker.sv @@
// gle_checker: port-level assertions for gif_lzw_encoder, bound to the top
// depends on gif_lzw_encoder
`timescale 1ns / 1ps
module gle_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       stream_end,
  input logic       last_of_run
);

  // clearing pass holds off pixels right after reset
  a_reset_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // one pixel at a time
  a_one_pixel: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second pixel taken back to back");

  // the final byte of a stream also closes its pixel
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> last_of_run)
    else $error("stream_end without last_of_run");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output word changed while stalled");

endmodule

bind gif_lzw_encoder gle_checker u_gle_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .stream_end  (stream_end),
  .last_of_run (last_of_run)
);

@@ verif/tb_gif_lzw_encoder.sv @@
// tb_gif_lzw_encoder: self-checking testbench for the gif lzw encoder
// depends on gle_pkg and gif_lzw_encoder; holds its own lzw predictor with hash dictionary
`timescale 1ns / 1ps
module tb_gif_lzw_encoder;
  import gle_pkg::*;

  localparam int SETTLE_CYCLES = 200;   // margin for probe chains after the last byte
  localparam int STALL_LIMIT   = 40000; // cycles with no word moving before giving up
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int FILL_PIXELS   = 280;   // enough bytes at size 8 to cross a sub-block

  // one expected byte word
  typedef struct {
    logic [7:0] data;
    bit         blk;
    bit         fin;
    bit         lor;
  } byte_word_t;

  // one row of the directed table; exp_n > 0 means bytes typed in by hand
  typedef struct {
    bit         wr;
    logic [3:0] size;
    logic [7:0] pix;
    bit         last;
    int         exp_n;
    logic [7:0] exp_b [4];
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel;
  logic        last_pixel;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        block_end;
  logic        stream_end;
  logic        last_of_run;

  gif_lzw_encoder uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .block_end(block_end), .stream_end(stream_end), .last_of_run(last_of_run)
  );

  // clock, 20 ns period
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // predictor state: dictionary slots and coder registers
  logic [19:0] dict_key  [HASH_SLOTS];
  logic [11:0] dict_code [HASH_SLOTS];
  logic [15:0] dict_gen  [HASH_SLOTS];
  logic [15:0] gen_ctr;
  logic [11:0] cur_prefix;
  bit          have_prefix;
  int unsigned free_code;
  int unsigned width;
  int unsigned acc_bits;
  int unsigned acc_cnt;
  int unsigned blk_cnt;
  bit          in_stream;
  logic [3:0]  size_reg;
  int unsigned size_used;

  byte_word_t  bytes_due [$];
  int          errors;
  int          dir_errors;
  int          hold_req;
  int          hold_done;
  int          burst_left;
  bit          back_to_back;
  dir_row_t    rows [$];

  function automatic int unsigned slot_of(input logic [19:0] key);
    logic [19:0] h;
    h = key ^ (key >> 16);
    h = h ^ (h >> 8);
    return int'(h) % HASH_SLOTS;
  endfunction

  task automatic emit_byte(input int unsigned b);
    byte_word_t w;
    blk_cnt++;
    w.data = b[7:0];
    w.blk  = 1'b0;
    w.fin  = 1'b0;
    w.lor  = 1'b0;
    if (blk_cnt >= SUB_BLOCK_BYTES) begin
      w.blk   = 1'b1;
      blk_cnt = 0;
    end
    bytes_due.push_back(w);
  endtask

  task automatic put_code(input int unsigned code);
    code &= (32'd1 << width) - 1;
    acc_bits |= code << acc_cnt;
    acc_cnt += width;
    while (acc_cnt >= 8) begin
      emit_byte(acc_bits & 8'hFF);
      acc_bits >>= 8;
      acc_cnt -= 8;
    end
  endtask

  task automatic restart_dict();
    free_code = (32'd1 << size_used) + 2;
    width     = size_used + 1;
    gen_ctr++;
    // generation wrap wipes every slot
    if (gen_ctr == 16'd0) begin
      foreach (dict_gen[i]) begin
        dict_gen[i]  = '0;
        dict_key[i]  = '0;
        dict_code[i] = '0;
      end
      gen_ctr = 16'd1;
    end
  endtask

  // one pixel through the lzw coder, expected bytes go to bytes_due
  task automatic lzw_step(input logic [7:0] p, input bit l);
    int unsigned clr;
    int unsigned n0;
    int unsigned idx;
    logic [19:0] key;
    bit          hit;
    logic [11:0] found;
    bit          done;
    n0 = bytes_due.size();
    if (!in_stream) begin
      size_used = (size_reg < 2) ? 2 : (size_reg > 8) ? 8 : size_reg;
      restart_dict();
      in_stream   = 1'b1;
      have_prefix = 1'b0;
      put_code(32'd1 << size_used);
    end
    clr = 32'd1 << size_used;
    if (!have_prefix) begin
      cur_prefix  = {4'd0, p};
      have_prefix = 1'b1;
    end else begin
      key  = {cur_prefix, p};
      hit  = 1'b0;
      done = 1'b0;
      idx  = slot_of(key);
      for (int n = 0; n < HASH_SLOTS && !done; n++) begin
        if (dict_gen[idx] != gen_ctr) done = 1'b1;
        else if (dict_key[idx] == key) begin
          hit   = 1'b1;
          found = dict_code[idx];
          done  = 1'b1;
        end else idx = (idx + 1) % HASH_SLOTS;
      end
      if (hit) cur_prefix = found;
      else begin
        put_code(cur_prefix);
        if (free_code < DICT_LIMIT) begin
          // first stale slot along the probe chain takes the new string
          done = 1'b0;
          idx  = slot_of(key);
          for (int n = 0; n < HASH_SLOTS && !done; n++) begin
            if (dict_gen[idx] != gen_ctr) begin
              dict_key[idx]  = key;
              dict_code[idx] = free_code[11:0];
              dict_gen[idx]  = gen_ctr;
              done = 1'b1;
            end else idx = (idx + 1) % HASH_SLOTS;
          end
          if (free_code > (32'd1 << width) - 1 && width < WIDTH_LIMIT) width++;
          free_code++;
        end else begin
          // dictionary full: clear code at width 12, then start over
          put_code(clr);
          restart_dict();
        end
        cur_prefix = {4'd0, p};
      end
    end
    if (l) begin
      put_code(cur_prefix);
      put_code(clr + 1);
      if (acc_cnt > 0) emit_byte(acc_bits & 8'hFF);
      if (bytes_due.size() > n0) bytes_due[bytes_due.size()-1].fin = 1'b1;
      acc_bits    = 0;
      acc_cnt     = 0;
      blk_cnt     = 0;
      have_prefix = 1'b0;
      in_stream   = 1'b0;
    end
    if (bytes_due.size() > n0) bytes_due[bytes_due.size()-1].lor = 1'b1;
  endtask

  // offer one pixel word, with burst gaps unless back to back
  task automatic send_pixel(input logic [7:0] p, input bit l);
    int gap;
    if (!back_to_back) begin
      if (burst_left <= 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    pixel      <= p;
    last_pixel <= l;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    lzw_step(p, l);
  endtask

  // sender stops until every expected byte is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of the code size register, only called while idle
  task automatic write_size(input logic [3:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= {28'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    size_reg = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_row(input bit wr, input logic [3:0] size, input logic [7:0] p,
                         input bit l, input int n, input logic [31:0] b);
    dir_row_t r;
    r.wr    = wr;
    r.size  = size;
    r.pix   = p;
    r.last  = l;
    r.exp_n = n;
    for (int i = 0; i < 4; i++) r.exp_b[i] = b[8*i +: 8];
    rows.push_back(r);
  endtask

  // byte checker: oldest expectation against each accepted word
  initial errors = 0;
  always @(posedge clk) begin
    byte_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        $error("unexpected byte word %02h", out_byte);
        errors++;
      end else begin
        w = bytes_due.pop_front();
        if (out_byte !== w.data) begin
          $error("out_byte expected %02h got %02h", w.data, out_byte);
          errors++;
        end
        if (block_end !== w.blk) begin
          $error("block_end expected %0d got %0d", w.blk, block_end);
          errors++;
        end
        if (stream_end !== w.fin) begin
          $error("stream_end expected %0d got %0d", w.fin, stream_end);
          errors++;
        end
        if (last_of_run !== w.lor) begin
          $error("last_of_run expected %0d got %0d", w.lor, last_of_run);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles where no word moves
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: stall pattern drawn anew each time the phase counter wraps, plus one long hold-off
  initial begin
    int ph;
    int mode;
    ph        = 0;
    mode      = 0;
    hold_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (ph == 0) mode = $urandom_range(0, 2);
        ph = (ph + 1) % 64;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= ($urandom_range(0, 1) == 1);
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    int          len;
    logic [3:0]  sz;
    logic [7:0]  p;
    int unsigned n0;
    dir_errors   = 0;
    hold_req     = 0;
    burst_left   = 0;
    back_to_back = 1'b0;
    // predictor reset state
    foreach (dict_gen[i]) begin
      dict_gen[i]  = '0;
      dict_key[i]  = '0;
      dict_code[i] = '0;
    end
    gen_ctr     = '0;
    cur_prefix  = '0;
    have_prefix = 1'b0;
    size_reg    = 4'd8;
    size_used   = 8;
    free_code   = 258;
    width       = 9;
    acc_bits    = 0;
    acc_cnt     = 0;
    blk_cnt     = 0;
    in_stream   = 1'b0;

    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= 3'd0;
    pwdata     <= 32'd0;
    in_valid   <= 1'b0;
    pixel      <= 8'd0;
    last_pixel <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: three single-pixel streams have hand-worked bytes
    add_row(1, 4'd8, 8'd0,   1, 4, 32'h04040100);
    add_row(0, 4'd8, 8'd255, 1, 4, 32'h0405FF00);
    for (int i = 0; i < 6; i++) add_row(0, 4'd8, 8'd7, i == 5, 0, 0);
    add_row(1, 4'd2, 8'd0,   1, 2, 32'h00000144);
    add_row(0, 4'd2, 8'd3,   0, 0, 0);
    add_row(0, 4'd2, 8'd0,   0, 0, 0);
    add_row(0, 4'd2, 8'd1,   0, 0, 0);
    add_row(0, 4'd2, 8'd2,   0, 0, 0);
    add_row(0, 4'd2, 8'd200, 1, 0, 0);   // out of range, masked to code width
    add_row(1, 4'd0, 8'd1,   0, 0, 0);   // size below range counts as 2
    add_row(0, 4'd0, 8'd1,   1, 0, 0);
    add_row(1, 4'd15, 8'd128, 0, 0, 0);  // size above range counts as 8
    add_row(0, 4'd15, 8'd128, 1, 0, 0);
    add_row(1, 4'd9, 8'd64,  1, 0, 0);
    foreach (rows[i]) begin
      if (rows[i].wr) begin
        drain();
        write_size(rows[i].size);
      end else if (rows[i].exp_n > 0) begin
        drain();
      end
      n0 = bytes_due.size();
      send_pixel(rows[i].pix, rows[i].last);
      for (int k = 0; k < rows[i].exp_n; k++)
        if (bytes_due[n0+k].data !== rows[i].exp_b[k]) begin
          $error("out_byte expected %02h got %02h", rows[i].exp_b[k], bytes_due[n0+k].data);
          dir_errors++;
        end
    end

    // long receiver hold-off while pixels keep coming back to back
    drain();
    write_size(4'd8);
    back_to_back = 1'b1;
    hold_req++;
    for (int i = 0; i < 120; i++) send_pixel(8'($urandom_range(0, 255)), i == 119);
    back_to_back = 1'b0;

    // register written mid-stream: takes effect at next stream start
    send_pixel(8'd5, 0);
    send_pixel(8'd6, 0);
    drain();
    write_size(4'd3);
    send_pixel(8'd200, 0);
    send_pixel(8'd6, 1);
    send_pixel(8'd7, 1);

    // random streams, most with in-range pixels
    for (int s = 0; s < 10; s++) begin
      drain();
      case ($urandom_range(0, 5))
        0: sz = 4'd2;
        1: sz = 4'd8;
        2: sz = 4'($urandom_range(0, 15));
        default: sz = 4'($urandom_range(2, 8));
      endcase
      write_size(sz);
      if (sz < 2) sz = 4'd2;
      if (sz > 8) sz = 4'd8;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) p = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 3) == 0) p = 8'($urandom_range(0, 1));
        else p = 8'($urandom_range(0, (1 << sz) - 1));
        send_pixel(p, i == len - 1);
      end
    end

    // one stream long enough to cross sub-blocks
    drain();
    write_size(4'd8);
    for (int i = 0; i < FILL_PIXELS; i++)
      send_pixel(8'($urandom_range(0, 255)), i == FILL_PIXELS - 1);

    drain();
    if (errors == 0 && dir_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/gle_pkg.sv
design/gle_table.sv
design/gif_lzw_encoder.sv
design/gle_checker.sv
verif/tb_gif_lzw_encoder.sv
